>>> rtl/core/cfq_pkg.sv
package cfq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 4;
    localparam int WORD_W = 32;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [WORD_W-1:0] NONE_WORD = '1;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_word wdata;
        logic  re;
        t_idx  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [1:0] status;
        t_word      popped;
        t_word      oldest;
        t_word      newest;
        t_count     count;
        logic       empty;
        logic       full;
    } t_result;

    function automatic t_idx wrap_next(input t_idx i);
        if (i == t_idx'(DEPTH - 1)) begin
            return '0;
        end
        return i + t_idx'(1);
    endfunction

    // Entries held: (tail - head) mod DEPTH, reported in the low count bits.
    function automatic t_count fill_count(input t_idx tail, input t_idx head);
        logic [IDX_W:0] diff;
        diff = {1'b0, tail} - {1'b0, head};
        if (tail < head) begin
            diff = diff + (IDX_W+1)'(DEPTH);
        end
        return t_count'(diff);
    endfunction

endpackage

>>> rtl/core/cfq_ram.sv
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/core/cfq_ctrl.sv
module cfq_ctrl
    import cfq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  t_word      i_push_value,
    output t_mem_req   o_mem,
    input  t_word      i_rdata,
    output logic       o_res_valid,
    output t_result    o_res,
    input  logic       i_res_take
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic       r_state, n_state;
    t_idx       r_head, n_head;
    t_idx       r_tail, n_tail;
    t_word      r_oldest, n_oldest;
    t_word      r_newest, n_newest;
    logic [1:0] r_status, n_status;
    t_word      r_popped, n_popped;
    t_count     r_count, n_count;
    logic       r_empty, n_empty;
    logic       r_full, n_full;
    logic       r_need_read, n_need_read;

    logic       empty_now;
    logic       full_now;
    t_idx       head_adv;

    assign empty_now = (r_head == r_tail);
    assign full_now  = (wrap_next(r_tail) == r_head);
    assign head_adv  = wrap_next(r_head);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_status    = r_status;
        n_popped    = r_popped;
        n_count     = r_count;
        n_empty     = r_empty;
        n_full      = r_full;
        n_need_read = r_need_read;
        o_mem.we    = 1'b0;
        o_mem.waddr = wrap_next(r_tail);
        o_mem.wdata = i_push_value;
        o_mem.re    = 1'b0;
        o_mem.raddr = wrap_next(head_adv);

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state     = ST_RESP;
                    n_status    = STAT_OK;
                    n_popped    = NONE_WORD;
                    n_need_read = 1'b0;
                    case (i_func)
                        FUNC_PUSH: begin
                            if (full_now) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_tail   = wrap_next(r_tail);
                                o_mem.we = 1'b1;
                                n_newest = i_push_value;
                                if (empty_now) begin
                                    n_oldest = i_push_value;
                                end
                            end
                        end
                        FUNC_POP: begin
                            if (empty_now) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_head   = head_adv;
                                n_popped = r_oldest;
                                // Fetch the entry behind the popped one as the new oldest.
                                if (head_adv != r_tail) begin
                                    o_mem.re    = 1'b1;
                                    n_need_read = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_empty = (n_head == n_tail);
                    n_full  = (wrap_next(n_tail) == n_head);
                    n_count = fill_count(n_tail, n_head);
                end
            end
            ST_RESP: begin
                if (r_need_read) begin
                    n_oldest = i_rdata;
                end
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oldest    <= n_oldest;
        r_newest    <= n_newest;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_count     <= n_count;
        r_empty     <= n_empty;
        r_full      <= n_full;
        r_need_read <= n_need_read;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_RESP);

    always_comb begin
        o_res.status = r_status;
        o_res.popped = r_popped;
        o_res.oldest = r_empty ? NONE_WORD : (r_need_read ? i_rdata : r_oldest);
        o_res.newest = r_empty ? NONE_WORD : r_newest;
        o_res.count  = r_count;
        o_res.empty  = r_empty;
        o_res.full   = r_full;
    end

endmodule

>>> rtl/core/circular_fifo_queue.sv
// A result is registered in the controller, then in the output register.
// A new request waits until the previous result has left the controller; the
// registered slot-memory read (new oldest entry after a dequeue) lands meanwhile.
// A full output register stalled downstream holds further requests back.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
module circular_fifo_queue
    import cfq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [1:0]   i_func,
    input  logic signed [31:0] i_push_value,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [1:0]   o_status,
    output logic signed [31:0] o_popped_value,
    output logic signed [31:0] o_oldest_value,
    output logic signed [31:0] o_newest_value,
    output logic [3:0]   o_entry_count,
    output logic         o_is_empty,
    output logic         o_is_full
);

    t_mem_req mem_req;
    t_word    rdata;
    logic     res_valid;
    t_result  res;
    logic     res_take;

    logic     r_out_valid;
    t_result  r_out;

    cfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    cfq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_mem        (mem_req),
        .i_rdata      (rdata),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_popped_value = r_out.popped;
    assign o_oldest_value = r_out.oldest;
    assign o_newest_value = r_out.newest;
    assign o_entry_count  = r_out.count;
    assign o_is_empty     = r_out.empty;
    assign o_is_full      = r_out.full;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still in flight");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_entry_count == '0 && !o_is_full))
        else $error("empty flag disagrees with entry count");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |->
            (o_oldest_value == NONE_WORD && o_newest_value == NONE_WORD))
        else $error("empty queue reports stored words");

    a_refused_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_EMPTY) |->
            (o_is_empty && o_popped_value == NONE_WORD))
        else $error("dequeue on empty queue returned a word");

endmodule
